FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);
`endif

FILE: rtl/pvma_pkg.sv
package pvma_pkg;
   localparam int NUM_SUMS = 10;
   localparam int SUM_W    = 64;
   localparam int NUM_AXES = 3;
   // per-triangle term width, products stay well under this
   localparam int TERM_W   = 64;
   localparam int CRD_W    = 10;

   typedef logic signed [TERM_W-1:0] term_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   // what one axis lane produces
   typedef struct packed {
      term_type f1;
      term_type f2;
      term_type f3;
      term_type g0;
      term_type g1;
      term_type g2;
   } axis_terms_type;

   // control handed from the lane stage to the merge stage
   typedef struct packed {
      logic valid;
      logic last;
   } stage_ctl_type;

   function automatic sum_type sat_add(sum_type a, term_type b);
      logic signed [SUM_W:0] s;
      s = {a[SUM_W-1], a} + {b[TERM_W-1], b};
      if (s[SUM_W] != s[SUM_W-1])
         sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      else
         sat_add = s[SUM_W-1:0];
   endfunction
endpackage

FILE: rtl/pvma_axis_lane.sv
// one axis: f and g polynomial terms over two registered stages
module pvma_axis_lane #(
   parameter int COORD_BITS = 10
) (
   input  logic                          clock,
   input  logic                          advance,
   input  logic signed [COORD_BITS-1:0]  w0,
   input  logic signed [COORD_BITS-1:0]  w1,
   input  logic signed [COORD_BITS-1:0]  w2,
   output pvma_pkg::axis_terms_type      terms
);
   localparam int SW = 2*COORD_BITS + 4;
   logic signed [SW-1:0] p_ff, p_in, f2_ff, f2_in, sq0_ff, sq0_in;
   logic signed [COORD_BITS+1:0] f1_ff, f1_in;
   logic signed [COORD_BITS-1:0] w0_ff, w1_ff, w2_ff;
   pvma_pkg::axis_terms_type terms_ff, terms_in;
   logic signed [COORD_BITS+1:0] s01;

   always_comb begin
      s01    = (COORD_BITS+2)'(w0) + (COORD_BITS+2)'(w1);
      f1_in  = s01 + (COORD_BITS+2)'(w2);
      sq0_in = SW'(w0 * w0);
      p_in   = sq0_in + SW'(w1 * s01);
      f2_in  = p_in + SW'(w2 * f1_in);
   end

   always_comb begin
      terms_in.f1 = pvma_pkg::TERM_W'(f1_ff);
      terms_in.f2 = pvma_pkg::TERM_W'(f2_ff);
      terms_in.f3 = pvma_pkg::TERM_W'(w0_ff * sq0_ff) + pvma_pkg::TERM_W'(w1_ff * p_ff)
                  + pvma_pkg::TERM_W'(w2_ff * f2_ff);
      terms_in.g0 = pvma_pkg::TERM_W'(f2_ff) + pvma_pkg::TERM_W'(w0_ff * (f1_ff + w0_ff));
      terms_in.g1 = pvma_pkg::TERM_W'(f2_ff) + pvma_pkg::TERM_W'(w1_ff * (f1_ff + w1_ff));
      terms_in.g2 = pvma_pkg::TERM_W'(f2_ff) + pvma_pkg::TERM_W'(w2_ff * (f1_ff + w2_ff));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_ff <= p_in;
         f2_ff <= f2_in;
         sq0_ff <= sq0_in;
         f1_ff <= f1_in;
         w0_ff <= w0;
         w1_ff <= w1;
         w2_ff <= w2;
         terms_ff <= terms_in;
      end
   end

   assign terms = terms_ff;
endmodule

FILE: rtl/pvma_merge.sv
`include "assert_macros.svh"
// forms the normal, the ten products and saturating sums
module pvma_merge #(
   parameter int COORD_BITS = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  pvma_pkg::stage_ctl_type            ctl,
   input  logic signed [COORD_BITS-1:0]       crd [9],
   input  pvma_pkg::axis_terms_type           tx,
   input  pvma_pkg::axis_terms_type           ty,
   input  pvma_pkg::axis_terms_type           tz,
   output logic                               done,
   output pvma_pkg::sum_type                  sums [pvma_pkg::NUM_SUMS]
);
   localparam int EW = COORD_BITS + 1;
   localparam int NW = 2*EW + 1;
   // value ranges of the lane terms, keeps the multipliers narrow
   localparam int F1W = COORD_BITS + 2;
   localparam int F2W = 2*COORD_BITS + 4;
   localparam int F3W = 3*COORD_BITS + 3;
   localparam int MW  = 3*COORD_BITS + 4;
   logic signed [EW-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
   logic signed [NW-1:0] n_in [3];
   logic signed [NW-1:0] n_ff [3];
   pvma_pkg::term_type   mix_in [3];
   pvma_pkg::term_type   mix_ff [3];
   pvma_pkg::axis_terms_type tx_ff, ty_ff, tz_ff;
   pvma_pkg::term_type   term [pvma_pkg::NUM_SUMS];
   pvma_pkg::sum_type    acc_ff [pvma_pkg::NUM_SUMS];
   logic                 v_ff, last_ff, done_ff;

   always_comb begin
      e1x = EW'(crd[3]) - EW'(crd[0]);
      e1y = EW'(crd[4]) - EW'(crd[1]);
      e1z = EW'(crd[5]) - EW'(crd[2]);
      e2x = EW'(crd[6]) - EW'(crd[0]);
      e2y = EW'(crd[7]) - EW'(crd[1]);
      e2z = EW'(crd[8]) - EW'(crd[2]);
      n_in[0] = NW'(e1y * e2z) - NW'(e1z * e2y);
      n_in[1] = NW'(e1z * e2x) - NW'(e1x * e2z);
      n_in[2] = NW'(e1x * e2y) - NW'(e1y * e2x);
      mix_in[0] = pvma_pkg::TERM_W'($signed(tx.g0[F2W-1:0]) * crd[1]
                                  + $signed(tx.g1[F2W-1:0]) * crd[4]
                                  + $signed(tx.g2[F2W-1:0]) * crd[7]);
      mix_in[1] = pvma_pkg::TERM_W'($signed(ty.g0[F2W-1:0]) * crd[2]
                                  + $signed(ty.g1[F2W-1:0]) * crd[5]
                                  + $signed(ty.g2[F2W-1:0]) * crd[8]);
      mix_in[2] = pvma_pkg::TERM_W'($signed(tz.g0[F2W-1:0]) * crd[0]
                                  + $signed(tz.g1[F2W-1:0]) * crd[3]
                                  + $signed(tz.g2[F2W-1:0]) * crd[6]);
   end

   always_comb begin
      term[0] = pvma_pkg::TERM_W'(n_ff[0] * $signed(tx_ff.f1[F1W-1:0]));
      term[1] = pvma_pkg::TERM_W'(n_ff[0] * $signed(tx_ff.f2[F2W-1:0]));
      term[2] = pvma_pkg::TERM_W'(n_ff[1] * $signed(ty_ff.f2[F2W-1:0]));
      term[3] = pvma_pkg::TERM_W'(n_ff[2] * $signed(tz_ff.f2[F2W-1:0]));
      term[4] = pvma_pkg::TERM_W'(n_ff[0] * $signed(tx_ff.f3[F3W-1:0]));
      term[5] = pvma_pkg::TERM_W'(n_ff[1] * $signed(ty_ff.f3[F3W-1:0]));
      term[6] = pvma_pkg::TERM_W'(n_ff[2] * $signed(tz_ff.f3[F3W-1:0]));
      term[7] = pvma_pkg::TERM_W'(n_ff[0] * $signed(mix_ff[0][MW-1:0]));
      term[8] = pvma_pkg::TERM_W'(n_ff[1] * $signed(mix_ff[1][MW-1:0]));
      term[9] = pvma_pkg::TERM_W'(n_ff[2] * $signed(mix_ff[2][MW-1:0]));
   end

   always_ff @(posedge clock) begin
      if (ctl.valid) begin
         n_ff <= n_in;
         mix_ff <= mix_in;
         tx_ff <= tx;
         ty_ff <= ty;
         tz_ff <= tz;
      end
      if (reset) begin
         v_ff <= 1'b0;
         last_ff <= 1'b0;
         done_ff <= 1'b0;
         for (int i = 0; i < pvma_pkg::NUM_SUMS; i++) acc_ff[i] <= '0;
      end else begin
         v_ff <= ctl.valid;
         last_ff <= ctl.last;
         done_ff <= v_ff && last_ff;
         for (int i = 0; i < pvma_pkg::NUM_SUMS; i++) begin
            if (v_ff) acc_ff[i] <= pvma_pkg::sat_add(done_ff ? '0 : acc_ff[i], term[i]);
            else if (done_ff) acc_ff[i] <= '0;
         end
      end
   end

   assign done = done_ff;
   assign sums = acc_ff;

   `ASSERT_NEXT(a_done_follows_last, clock, reset, v_ff && last_ff, done_ff, "done lost")
   `ASSERT_NEXT(a_no_spurious_done, clock, reset, !(v_ff && last_ff), !done_ff, "bad done")
endmodule

FILE: rtl/polyhedron_volume_moment_accumulator.sv
// polyhedron volume/moment accumulator: takes one triangle per item and keeps ten
// saturating 64-bit sums (6*volume, 24*first moments, 60*second moments, 120*products);
// on an item with last set it emits the sums on the rsp side and clears them.
// path: one item goes through three lanes in two register stages, the merge
// stage (normal and mixed terms), the accumulate and the output register with its
// valid flag rsp_tvalid; items are taken one at a time and the next one is accepted
// only once the state machine has counted the previous one through the pipeline
// and gone back to idle. results wait in an output register while new
// items keep flowing; only a last item that finds a result still waiting holds
// before the merge stage until that result is taken.
`include "assert_macros.svh"
module polyhedron_volume_moment_accumulator #(
   parameter int COORD_BITS = 10
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (10 bits each), 6 zero bits
   input  logic [95:0]   req_tdata,
   input  logic          req_tlast,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // vol, mom x/y/z, sq x/y/z, prod xy/yz/zx, 64 bits each
   output logic [639:0]  rsp_tdata
);
   localparam int DEPTH = 5;
   typedef enum logic {IDLE, BUSY} st_type;
   st_type st_ff;
   logic [2:0] cnt_ff;
   logic last_ff;
   logic rsp_valid_ff;
   logic signed [COORD_BITS-1:0] crd_ff [9];
   logic [639:0] out_ff;
   logic lane_go, done, merge_wait;
   pvma_pkg::stage_ctl_type ctl;
   pvma_pkg::axis_terms_type tx, ty, tz;
   pvma_pkg::sum_type sums [pvma_pkg::NUM_SUMS];

   assign req_tready = (st_ff == IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = out_ff;

   // a last item must not reach the output while a result still waits there
   assign merge_wait = (cnt_ff == 3'd2) && last_ff && rsp_valid_ff;

   // lanes advance from the cycle after capture; merge then takes their terms
   assign lane_go = (st_ff == BUSY) && (cnt_ff < 3'd2);
   assign ctl.valid = (st_ff == BUSY) && (cnt_ff == 3'd2) && !merge_wait;
   assign ctl.last = last_ff;

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         for (int i = 0; i < 9; i++) crd_ff[i] <= req_tdata[i*pvma_pkg::CRD_W +: COORD_BITS];
      end
      if (done) begin
         for (int i = 0; i < pvma_pkg::NUM_SUMS; i++) out_ff[i*64 +: 64] <= sums[i];
      end
      if (reset) begin
         st_ff <= IDLE;
         cnt_ff <= '0;
         last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (done) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         case (st_ff)
            IDLE: begin
               if (req_tvalid) begin
                  st_ff <= BUSY;
                  cnt_ff <= '0;
                  last_ff <= req_tlast;
               end
            end
            BUSY: begin
               if (!merge_wait) begin
                  cnt_ff <= cnt_ff + 3'd1;
                  if (cnt_ff == 3'(DEPTH)) st_ff <= IDLE;
               end
            end
            default: st_ff <= IDLE;
         endcase
      end
   end

   pvma_axis_lane #(.COORD_BITS(COORD_BITS)) u_lane_x (
      .clock(clock), .advance(lane_go),
      .w0(crd_ff[0]), .w1(crd_ff[3]), .w2(crd_ff[6]), .terms(tx));
   pvma_axis_lane #(.COORD_BITS(COORD_BITS)) u_lane_y (
      .clock(clock), .advance(lane_go),
      .w0(crd_ff[1]), .w1(crd_ff[4]), .w2(crd_ff[7]), .terms(ty));
   pvma_axis_lane #(.COORD_BITS(COORD_BITS)) u_lane_z (
      .clock(clock), .advance(lane_go),
      .w0(crd_ff[2]), .w1(crd_ff[5]), .w2(crd_ff[8]), .terms(tz));

   pvma_merge #(.COORD_BITS(COORD_BITS)) u_merge (
      .clock(clock), .reset(reset), .ctl(ctl), .crd(crd_ff),
      .tx(tx), .ty(ty), .tz(tz), .done(done), .sums(sums));

   `ASSERT_IMPL(a_done_in_busy, clock, reset, done, st_ff == BUSY, "done outside busy")
   `ASSERT_NEXT(a_send_holds, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "result dropped")
   `ASSERT_IMPL(a_lane_before_merge, clock, reset, ctl.valid, !lane_go, "lane overlap")
   `ASSERT_IMPL(a_no_overwrite, clock, reset, done, !rsp_valid_ff, "result overwritten")
endmodule
